@@ rtl/core/dwc_pkg.sv @@
// Shared types and constants for the 3x3 depthwise convolution block.
// No dependencies; imported by dwc_mac and depthwise_conv3x3_relu6_top.
package dwc_pkg;

    typedef logic signed [15:0] word_t;
    typedef word_t nine_t [9];

    // Control that travels with one window through the arithmetic pipeline.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [8:0] mask;
    } mac_op_t;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_COEF  = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RELU   = 2'd2;

    localparam logic [3:0] NUM_TAPS   = 4'd9;
    localparam logic [3:0] BIAS_INDEX = 4'd9;

    localparam int ACC_W      = 36;
    localparam int FRAC_SHIFT = 14;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 36'sd8192;
    localparam logic signed [Q_W-1:0]   SAT_MAX    = 22'sd32767;
    localparam logic signed [Q_W-1:0]   SAT_MIN    = -22'sd32768;
    localparam word_t                   RELU6_MAX  = 16'sd1536;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

endpackage

@@ rtl/core/dwc_mac.sv @@
// Multiply, sum, round and clamp pipeline for one 3x3 window.
// Depends on dwc_pkg; instantiated by depthwise_conv3x3_relu6_top.
module dwc_mac
    import dwc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mac_op_t op,
    input  nine_t   win,
    input  nine_t   taps,
    input  word_t   bias,
    input  logic    relu,
    output logic    res_valid,
    output word_t   res_value,
    output logic    res_last
);

    logic signed [31:0]      prod_reg [9];
    word_t                   bias_reg;
    mac_op_t                 m1_op_reg;
    logic signed [ACC_W-1:0] psum_a_reg;
    logic signed [ACC_W-1:0] psum_b_reg;
    mac_op_t                 m2_op_reg;
    logic signed [ACC_W-1:0] acc_reg;
    mac_op_t                 m3_op_reg;
    word_t                   res_value_reg;
    logic                    res_valid_reg;
    logic                    res_last_reg;

    logic signed [ACC_W-1:0] psum_a_next;
    logic signed [ACC_W-1:0] psum_b_next;
    logic signed [ACC_W-1:0] rounded;
    logic signed [Q_W-1:0]   q;
    word_t                   sat;
    word_t                   res_value_next;

    // Masked products; taps outside the frame contribute zero.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            prod_reg[i] <= op.mask[i] ? (32'(win[i]) * 32'(taps[i])) : 32'sd0;
        end
        bias_reg <= bias;
    end

    always_comb
    begin
        psum_a_next = '0;
        for (int i = 0; i < 5; i++)
        begin
            psum_a_next = psum_a_next + ACC_W'(prod_reg[i]);
        end
        psum_b_next = ACC_W'(bias_reg) <<< FRAC_SHIFT;
        for (int i = 5; i < 9; i++)
        begin
            psum_b_next = psum_b_next + ACC_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        psum_a_reg <= psum_a_next;
        psum_b_reg <= psum_b_next;
        acc_reg    <= psum_a_reg + psum_b_reg;
    end

    // Round half up, then saturate and clamp.
    always_comb
    begin
        rounded = acc_reg + ROUND_HALF;
        q       = Q_W'(rounded >>> FRAC_SHIFT);
        if (q > SAT_MAX)
        begin
            sat = 16'sh7fff;
        end
        else if (q < SAT_MIN)
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = q[15:0];
        end
        res_value_next = sat;
        if (relu && sat < 16'sd0)
        begin
            res_value_next = 16'sd0;
        end
        else if (relu && sat > RELU6_MAX)
        begin
            res_value_next = RELU6_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_last_reg  <= m3_op_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_op_reg     <= '0;
            m2_op_reg     <= '0;
            m3_op_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            m1_op_reg     <= op;
            m2_op_reg     <= m1_op_reg;
            m3_op_reg     <= m2_op_reg;
            res_valid_reg <= m3_op_reg.valid;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;
    assign res_last  = res_last_reg;

endmodule

@@ rtl/core/depthwise_conv3x3_relu6_top.sv @@
// Top level of the streaming 3x3 depthwise convolution with optional ReLU6.
// Depends on dwc_pkg and dwc_mac.
//
// The block takes one item per clock unless in_stall is high: pixels in
// raster order, coefficient loads and drain items all enter at one per
// cycle. A drain item on a single-row plane that lands on the start of
// the lag region performs two window shifts and holds in_stall high while
// the second one runs. A result passes through registered stages (memory
// read, window shift, multiply, two adder levels, round/clamp) and then
// waits in an eight-entry output queue; input also stalls when results in
// flight plus queued results fill that queue. The two line rows live in
// one MAX_WIDTH x 32 synchronous memory (read, shift, write back in the
// next cycle, with forwarding when the same column is read right after it
// is written). Entries never written read as zero through a fill count, so
// no clearing pass runs after reset. Writing frame_width or frame_height
// restarts the plane; write configuration only while the block is idle.
module depthwise_conv3x3_relu6_top
    import dwc_pkg::*;
#(
    parameter int MAX_WIDTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [3:0]  coef_index,
    input  word_t       value,
    output logic        out_valid,
    input  logic        out_stall,
    output word_t       result,
    output logic        out_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // Configuration
    logic [8:0] fw_reg;
    logic [8:0] fh_reg;
    logic       relu_reg;

    // Positions
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [9:0]    in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [8:0]    out_row_reg, out_row_next;
    logic          second_reg, second_next;
    logic [WW-1:0] fill_reg, fill_next;

    // Line store: [31:16] older row, [15:0] previous row
    logic [31:0] lmem [MAX_WIDTH];
    logic [31:0] mem_q;

    // Stage 1
    logic          s1_valid_reg;
    logic [CW-1:0] s1_c_reg;
    word_t         s1_p_reg;
    logic          s1_fwd_reg;
    logic [31:0]   s1_fwd_data_reg;
    logic          s1_rvalid_reg;
    mac_op_t       s1_mac_reg;
    logic          s1_coef_we_reg;
    logic [3:0]    s1_coef_idx_reg;
    word_t         s1_coef_val_reg;

    mac_op_t s2_op_reg;
    nine_t   win_reg;
    nine_t   tap_reg;
    word_t   bias_reg;

    // Output queue
    logic [16:0]          oq_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [OUT_CNT_W-1:0] oq_cnt_reg;
    logic [OUT_CNT_W-1:0] credit_reg, credit_next;

    logic          res_valid;
    word_t         res_value;
    logic          res_last;

    logic [WW-1:0] w_eff;
    logic [8:0]    h_eff;
    logic          accept, k_pix, k_coef, k_drain;
    logic          pixels_due, issue, emits, col_end, plane_last, restart;
    logic [CW-1:0] c_sel;
    logic [2:0]    row_ok, col_ok;
    mac_op_t       s0_mac;
    logic [31:0]   rd_word, wdata;
    logic          out_take, credit_inc;

    always_comb
    begin
        if (fw_reg == 9'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(fw_reg);
        end
        h_eff = (fh_reg == 9'd0) ? 9'd1 : fh_reg;
    end

    assign in_stall = second_reg || (credit_reg >= OUT_CNT_W'(OUT_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign k_pix    = accept && (kind == KIND_PIXEL);
    assign k_coef   = accept && (kind == KIND_COEF);
    assign k_drain  = accept && (kind == KIND_DRAIN);

    // Decide what the accepted item does and advance both positions.
    always_comb
    begin
        pixels_due = in_row_reg < {1'b0, h_eff};
        issue      = (k_pix && pixels_due) || (k_drain && !pixels_due) || second_reg;
        c_sel      = (WW'(in_col_reg) < w_eff) ? in_col_reg : '0;
        col_end    = (WW'(c_sel) + WW'(1)) >= w_eff;
        emits      = !((in_row_reg == 10'd0) || (in_row_reg == 10'd1 && c_sel == '0));
        plane_last = (({1'b0, out_row_reg} + 10'd1) >= {1'b0, h_eff}) &&
                     ((WW'(out_col_reg) + WW'(1)) >= w_eff);
        row_ok     = {(({1'b0, out_row_reg} + 10'd1) < {1'b0, h_eff}), 1'b1,
                      (out_row_reg != 9'd0)};
        col_ok     = {((WW'(out_col_reg) + WW'(1)) < w_eff), 1'b1,
                      (out_col_reg != '0)};
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s0_mac.mask[k * 3 + j] = row_ok[k] && col_ok[j];
            end
        end
        s0_mac.valid = issue && emits;
        s0_mac.last  = plane_last;

        second_next = k_drain && !pixels_due && !emits;
        credit_inc  = (k_pix && pixels_due && emits) || (k_drain && !pixels_due);
        restart     = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (issue)
        begin
            in_col_next = col_end ? '0 : CW'(WW'(c_sel) + WW'(1));
            in_row_next = col_end ? in_row_reg + 10'd1 : in_row_reg;
            if (emits)
            begin
                if (plane_last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if ((WW'(out_col_reg) + WW'(1)) >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 9'd1;
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    // Stage 1: pick up the stored column, forwarded if it was just written.
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            rd_word = s1_fwd_data_reg;
        end
        else if (s1_rvalid_reg)
        begin
            rd_word = mem_q;
        end
        else
        begin
            rd_word = '0;
        end
        wdata     = {rd_word[15:0], s1_p_reg};
        fill_next = fill_reg;
        if (s1_valid_reg && (WW'(s1_c_reg) + WW'(1)) > fill_reg)
        begin
            fill_next = WW'(s1_c_reg) + WW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            mem_q <= lmem[c_sel];
        end
        if (s1_valid_reg)
        begin
            lmem[s1_c_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_c_reg        <= c_sel;
        s1_p_reg        <= k_pix ? value : 16'sd0;
        s1_fwd_data_reg <= wdata;
        s1_rvalid_reg   <= WW'(c_sel) < fill_reg;
        s1_coef_idx_reg <= coef_index;
        s1_coef_val_reg <= value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg         <= 9'd16;
            fh_reg         <= 9'd16;
            relu_reg       <= 1'b1;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            second_reg     <= 1'b0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_fwd_reg     <= 1'b0;
            s1_mac_reg     <= '0;
            s1_coef_we_reg <= 1'b0;
            s2_op_reg      <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  fw_reg   <= cfg_data;
                    REG_HEIGHT: fh_reg   <= cfg_data;
                    REG_RELU:   relu_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            second_reg     <= second_next;
            fill_reg       <= fill_next;
            s1_valid_reg   <= issue;
            s1_fwd_reg     <= issue && s1_valid_reg && (c_sel == s1_c_reg);
            s1_mac_reg     <= s0_mac;
            s1_coef_we_reg <= k_coef;
            s2_op_reg      <= s1_valid_reg ? s1_mac_reg : '0;
            credit_reg     <= credit_next;
        end
    end

    // Shift the window and apply coefficient loads in item order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= 16'sd0;
                tap_reg[i] <= 16'sd0;
            end
            bias_reg <= 16'sd0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k * 3]     <= win_reg[k * 3 + 1];
                    win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
                end
                win_reg[2] <= rd_word[31:16];
                win_reg[5] <= rd_word[15:0];
                win_reg[8] <= s1_p_reg;
            end
            if (s1_coef_we_reg)
            begin
                if (s1_coef_idx_reg < NUM_TAPS)
                begin
                    tap_reg[s1_coef_idx_reg] <= s1_coef_val_reg;
                end
                else if (s1_coef_idx_reg == BIAS_INDEX)
                begin
                    bias_reg <= s1_coef_val_reg;
                end
            end
        end
    end

    dwc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (s2_op_reg),
        .win       (win_reg),
        .taps      (tap_reg),
        .bias      (bias_reg),
        .relu      (relu_reg),
        .res_valid (res_valid),
        .res_value (res_value),
        .res_last  (res_last)
    );

    // Output queue; credit counts results in flight plus queued.
    assign out_take    = out_valid && !out_stall;
    assign credit_next = credit_reg + OUT_CNT_W'(credit_inc) - OUT_CNT_W'(out_take);

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            oq_mem[oq_wr_reg] <= {res_last, res_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (res_valid)
            begin
                oq_wr_reg <= oq_wr_reg + OUT_PTR_W'(1);
            end
            if (out_take)
            begin
                oq_rd_reg <= oq_rd_reg + OUT_PTR_W'(1);
            end
            oq_cnt_reg <= oq_cnt_reg + OUT_CNT_W'(res_valid) - OUT_CNT_W'(out_take);
        end
    end

    assign out_valid = oq_cnt_reg != '0;
    assign result    = oq_mem[oq_rd_reg][15:0];
    assign out_last  = oq_mem[oq_rd_reg][16];

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("credit count above queue depth");

    a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= credit_reg)
        else $error("queued results exceed credit");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_take) |-> (oq_cnt_reg < OUT_CNT_W'(OUT_DEPTH)))
        else $error("output queue overflow");

    a_second_shift: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (issue && emits))
        else $error("extra drain shift produced no result");

endmodule

@@ test/tb_depthwise_conv3x3_relu6_top.sv @@
// Testbench for depthwise_conv3x3_relu6_top: a directed table, then random planes,
// checked result by result against a predictor. Depends on dwc_pkg and the RTL top.
module tb_depthwise_conv3x3_relu6_top;
    import dwc_pkg::*;

    localparam int MAX_W         = 256;
    localparam int ITEM_TARGET   = 1550;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum int {CHK_NONE, CHK_TYPED, CHK_PRED} chk_e;

    typedef struct {
        logic [1:0] k;
        logic [3:0] ci;
        word_t      val;
        chk_e       chk;
        word_t      exp_val;
        logic       exp_last;
    } dir_row_t;

    typedef struct {
        word_t v;
        logic  last;
    } conv_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [3:0]  coef_index;
    word_t       value;
    logic        out_valid;
    logic        out_stall;
    word_t       result;
    logic        out_last;

    depthwise_conv3x3_relu6_top #(.MAX_WIDTH(MAX_W)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .coef_index(coef_index), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .result(result), .out_last(out_last)
    );

    // Predictor state: geometry, taps, line rows, window and plane positions.
    int unsigned geo_w, geo_h, relu_on;
    word_t       line_rows [2*MAX_W];
    word_t       win [3][3];
    word_t       taps [9];
    word_t       bias_q;
    int unsigned in_r, in_c, out_r, out_c;
    bit          saw_last;

    conv_result_t expected_results [$];

    int  err_count;
    int  items_sent;
    int  results_seen;
    int  planes_done;
    int  idle_cycles;
    bit  calm;
    bit  rx_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_w();
        if (geo_w == 0) return 1;
        if (geo_w > MAX_W) return MAX_W;
        return geo_w;
    endfunction

    function automatic int unsigned eff_h();
        return (geo_h == 0) ? 1 : geo_h;
    endfunction

    function automatic word_t conv_sum(int unsigned w, int unsigned h);
        longint acc;
        longint q;
        longint r;
        longint c;
        acc = longint'(bias_q) * 16384;
        for (int k = 0; k < 3; k++)
        begin
            r = longint'(out_r) - 1 + k;
            if (r < 0 || r >= h) continue;
            for (int j = 0; j < 3; j++)
            begin
                c = longint'(out_c) - 1 + j;
                if (c < 0 || c >= w) continue;
                acc += longint'(win[k][j]) * longint'(taps[k*3+j]);
            end
        end
        // Round half up, then floor: an arithmetic shift floors.
        q = (acc + 8192) >>> 14;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        if (relu_on != 0)
        begin
            if (q < 0) q = 0;
            if (q > 1536) q = 1536;
        end
        return word_t'(q);
    endfunction

    // Shift one value into the window; report a result when the lag is covered.
    function automatic bit conv_shift(word_t p, output conv_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned idx;
        word_t older;
        word_t old;
        w = eff_w();
        h = eff_h();
        c = (in_c < w) ? in_c : 0;
        idx = in_r * w + c;
        older = line_rows[MAX_W + c];
        old = line_rows[c];
        line_rows[MAX_W + c] = old;
        line_rows[c] = p;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = older;
        win[1][2] = old;
        win[2][2] = p;
        in_c = c + 1;
        if (in_c >= w)
        begin
            in_c = 0;
            in_r++;
        end
        if (idx < w + 1) return 0;
        res.v = conv_sum(w, h);
        if (out_r + 1 >= h && out_c + 1 >= w)
        begin
            res.last = 1'b1;
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        end
        else
        begin
            res.last = 1'b0;
            out_c++;
            if (out_c >= w)
            begin
                out_c = 0;
                out_r++;
            end
        end
        return 1;
    endfunction

    function automatic bit conv_step(logic [1:0] k, logic [3:0] ci, word_t v,
                                     output conv_result_t res);
        bit due;
        due = in_r < eff_h();
        res.v = '0;
        res.last = 1'b0;
        case (k)
            KIND_COEF:
            begin
                if (ci < NUM_TAPS) taps[ci] = v;
                else if (ci == BIAS_INDEX) bias_q = v;
                return 0;
            end
            KIND_PIXEL:
            begin
                if (!due) return 0;
                return conv_shift(v, res);
            end
            KIND_DRAIN:
            begin
                if (due) return 0;
                if (conv_shift('0, res)) return 1;
                return conv_shift('0, res);
            end
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned gap_len();
        if (calm || $urandom_range(0, 99) < 55) return 0;
        if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            4, 5: return word_t'($urandom_range(0, 2047)) - 16'sd1024;
            default: return word_t'($urandom);
        endcase
    endfunction

    // Offer one item after a random gap and hold it until taken; then predict.
    task automatic send_item(logic [1:0] k, logic [3:0] ci, word_t v,
                             output bit has, output conv_result_t res);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        coef_index <= ci;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        has = conv_step(k, ci, v, res);
        items_sent++;
    endtask

    task automatic send_checked(logic [1:0] k, logic [3:0] ci, word_t v);
        bit has;
        conv_result_t res;
        send_item(k, ci, v, has, res);
        if (has)
        begin
            expected_results.push_back(res);
            if (res.last) saw_last = 1'b1;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        // Deassert cfg_we between writes.
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WIDTH:
            begin
                geo_w = data;
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            end
            REG_HEIGHT:
            begin
                geo_h = data;
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            end
            REG_RELU: relu_on = data[0];
            default: ;
        endcase
    endtask

    // A random noise item: mostly harmless, sometimes a mid-plane coefficient.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_checked(KIND_UNUSED, 4'($urandom), rand_word());
            1: send_checked(KIND_DRAIN, 4'($urandom), rand_word());
            2: send_checked(KIND_COEF, 4'($urandom_range(10, 15)), rand_word());
            default: send_checked(KIND_COEF, 4'($urandom_range(0, 9)), rand_word());
        endcase
    endtask

    // One plane: geometry, coefficients, pixels with noise, then drain to the end unless cut short.
    task automatic run_plane(logic [8:0] w, logic [8:0] h, logic relu, bit cut_short);
        int unsigned npix;
        int unsigned stop_at;
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RELU, {8'd0, relu});
        for (int i = 0; i < 10; i++)
        begin
            // Keep taps mostly modest so that rounding, not saturation, dominates.
            if (i < 9 && $urandom_range(0, 3) != 0)
                send_checked(KIND_COEF, 4'(i), word_t'($urandom_range(0, 16383)) - 16'sd8192);
            else
                send_checked(KIND_COEF, 4'(i), rand_word());
        end
        npix = eff_w() * eff_h();
        stop_at = cut_short ? $urandom_range(1, npix) : npix;
        saw_last = 1'b0;
        for (int unsigned i = 0; i < stop_at; i++)
        begin
            if ($urandom_range(0, 99) < 6) send_noise();
            send_checked(KIND_PIXEL, 4'($urandom), rand_word());
        end
        // An abandoned plane is restarted by the next geometry write.
        if (cut_short && stop_at < npix) return;
        if ($urandom_range(0, 3) == 0) send_checked(KIND_PIXEL, 4'($urandom), rand_word());
        while (!saw_last)
        begin
            if ($urandom_range(0, 99) < 5) send_noise();
            send_checked(KIND_DRAIN, 4'($urandom), rand_word());
        end
        planes_done++;
    endtask

    // Receiver: random stall gaps, plus one long hold on request.
    initial
    begin
        int unsigned hold_cnt;
        int unsigned gap;
        hold_cnt = 0;
        gap = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
                out_stall <= 1'b1;
            end
            else if (gap > 0)
            begin
                gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                gap = gap_len();
                out_stall <= (gap > 0);
            end
        end
    end

    // Result checker and watchdog.
    initial
    begin
        conv_result_t exp_res;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || cfg_we) idle_cycles = 0;
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result result=%0d out_last=%0b", result, out_last);
                    err_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result !== exp_res.v)
                    begin
                        $error("result: expected %0d, got %0d", exp_res.v, result);
                        err_count++;
                    end
                    if (out_last !== exp_res.last)
                    begin
                        $error("out_last: expected %0b, got %0b", exp_res.last, out_last);
                        err_count++;
                    end
                end
            end
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: %0d cycles with no item moving", IDLE_LIMIT);
                $display("depthwise_conv3x3_relu6_top test failed");
                $finish;
            end
        end
    end

    // Stimulus.
    initial
    begin
        dir_row_t dir_rows [18];
        bit has;
        conv_result_t res;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        kind <= KIND_PIXEL;
        coef_index <= '0;
        value <= '0;
        err_count = 0;
        items_sent = 0;
        results_seen = 0;
        planes_done = 0;
        calm = 1'b0;
        rx_hold_req = 1'b0;

        geo_w = 16; geo_h = 16; relu_on = 1;
        foreach (line_rows[i]) line_rows[i] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        foreach (taps[i]) taps[i] = '0;
        bias_q = '0;
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 2x1 plane. With zero taps and full-scale bias the clamp gives 6.0.
        dir_rows = '{
            '{KIND_COEF,   4'd9,  16'sh7fff, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_UNUSED, 4'd0,  16'sh1234, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_COEF,   4'd12, 16'shffff, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_DRAIN,  4'd0,  16'sh0000, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_PIXEL,  4'd0,  16'sh8000, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_PIXEL,  4'd0,  16'sh7fff, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_PIXEL,  4'd0,  16'sh0005, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_DRAIN,  4'd0,  16'sh0000, CHK_TYPED, 16'sd1536, 1'b0},
            '{KIND_DRAIN,  4'd0,  16'sh0000, CHK_TYPED, 16'sd1536, 1'b1},
            '{KIND_COEF,   4'd0,  16'sh8000, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_COEF,   4'd8,  16'sh7fff, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_COEF,   4'd4,  16'sh4000, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_COEF,   4'd9,  16'sh8000, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_COEF,   4'd15, 16'sh7fff, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_PIXEL,  4'd0,  16'sh7fff, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_PIXEL,  4'd0,  16'sh8000, CHK_NONE,  16'sd0,    1'b0},
            '{KIND_DRAIN,  4'd0,  16'sh0000, CHK_PRED,  16'sd0,    1'b0},
            '{KIND_DRAIN,  4'd0,  16'sh0000, CHK_PRED,  16'sd0,    1'b0}
        };
        write_reg(REG_WIDTH, 9'd2);
        write_reg(REG_HEIGHT, 9'd1);
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].k, dir_rows[i].ci, dir_rows[i].val, has, res);
            case (dir_rows[i].chk)
                CHK_NONE:
                    if (has)
                    begin
                        $error("directed row %0d: predictor gave a result where none is due", i);
                        err_count++;
                    end
                CHK_TYPED: expected_results.push_back('{dir_rows[i].exp_val, dir_rows[i].exp_last});
                default: if (has) expected_results.push_back(res);
            endcase
        end

        // Corner geometries: zero width and height, 1x1, a width above the
        // maximum (acts as the full 256 columns) and a 256-row plane.
        run_plane(9'd0, 9'd0, 1'b0, 1'b0);
        run_plane(9'd1, 9'd1, 1'b1, 1'b0);
        run_plane(9'd511, 9'd1, 1'b0, 1'b0);
        run_plane(9'd1, 9'd256, 1'b0, 1'b0);

        // Back-pressure: hold the receiver while a full plane streams in.
        calm = 1'b1;
        rx_hold_req = 1'b1;
        run_plane(9'd16, 9'd4, 1'b1, 1'b0);
        calm = 1'b0;

        while (items_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 7) == 0);
            run_plane(9'($urandom_range(1, 9)), 9'($urandom_range(1, 6)),
                      1'($urandom), ($urandom_range(0, 7) == 0));
        end
        calm = 1'b0;

        wait_idle();
        $display("ran %0d items over %0d complete planes, %0d results checked",
                 items_sent, planes_done, results_seen);
        if (err_count == 0)
            $display("depthwise_conv3x3_relu6_top test passed");
        else
            $display("depthwise_conv3x3_relu6_top test failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/dwc_pkg.sv
rtl/core/dwc_mac.sv
rtl/core/depthwise_conv3x3_relu6_top.sv
test/tb_depthwise_conv3x3_relu6_top.sv
